@@ design/hsfd_pkg.sv @@
// Shared types, constants and the CRC-8 byte step for the sensor frame decoder.
// No dependencies; imported by every module of the block.
package hsfd_pkg;

  // CRC-8 as used by the sensor: poly x^8+x^5+x^4+1, init 0xFF, MSB first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions inside the six-byte readout
  localparam logic [2:0] BYTE_T_MSB = 3'd0;
  localparam logic [2:0] BYTE_T_LSB = 3'd1;
  localparam logic [2:0] BYTE_T_CRC = 3'd2;
  localparam logic [2:0] BYTE_H_MSB = 3'd3;
  localparam logic [2:0] BYTE_H_LSB = 3'd4;
  localparam logic [2:0] BYTE_H_CRC = 3'd5;
  localparam logic [2:0] FRAME_LEN  = 3'd6;

  // Scaling: centi-units = scale * raw / 65535, temperature offset -45.00 C
  localparam logic [14:0]        TEMP_SCALE  = 15'd17500;
  localparam logic [13:0]        HUM_SCALE   = 14'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

  // Job queue between the byte front end and the scaling back end
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TEMP_CRC = 2'd1,
    ST_HUM_CRC  = 2'd2,
    ST_BUS      = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
  } job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ design/hsfd_front.sv @@
// Front end: takes readout bytes, tracks frame position and CRC, and posts a job
// per finished or aborted frame. Depends on hsfd_pkg.
module hsfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic          q_full,
  output logic          push,
  output hsfd_pkg::job_t push_job
);
  import hsfd_pkg::*;

  logic [2:0]  idx_r, idx_nxt, idx_cur;
  logic [7:0]  crc_r, crc_nxt, crc_cur;
  logic        tok_r, tok_nxt, tok_cur;
  logic [15:0] raw_t_r, raw_t_nxt;
  logic [15:0] raw_h_r, raw_h_nxt;
  logic        in_fire;
  logic        restart;
  logic        hum_ok;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    restart   = in_tuser[0] || (idx_r >= FRAME_LEN);
    idx_cur   = restart ? BYTE_T_MSB : idx_r;
    crc_cur   = restart ? CRC_INIT : crc_r;
    tok_cur   = restart ? 1'b0 : tok_r;
    hum_ok    = (crc_cur == in_tdata);
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    tok_nxt   = tok_r;
    raw_t_nxt = raw_t_r;
    raw_h_nxt = raw_h_r;
    push      = 1'b0;
    push_job  = '{status: ST_BUS, raw_t: raw_t_r, raw_h: raw_h_r};
    if (in_fire) begin
      if (in_tuser[1]) begin
        // bus error: drop partial frame
        idx_nxt = BYTE_T_MSB;
        crc_nxt = CRC_INIT;
        tok_nxt = 1'b0;
        push    = 1'b1;
      end else begin
        idx_nxt = idx_cur + 3'd1;
        crc_nxt = crc_cur;
        tok_nxt = tok_cur;
        case (idx_cur)
          BYTE_T_MSB: begin
            raw_t_nxt = {in_tdata, 8'h00};
            crc_nxt   = crc8_byte(crc_cur, in_tdata);
          end
          BYTE_T_LSB: begin
            raw_t_nxt = {raw_t_r[15:8], in_tdata};
            crc_nxt   = crc8_byte(crc_cur, in_tdata);
          end
          BYTE_T_CRC: begin
            tok_nxt = (crc_cur == in_tdata);
            crc_nxt = CRC_INIT;
          end
          BYTE_H_MSB: begin
            raw_h_nxt = {in_tdata, 8'h00};
            crc_nxt   = crc8_byte(crc_cur, in_tdata);
          end
          BYTE_H_LSB: begin
            raw_h_nxt = {raw_h_r[15:8], in_tdata};
            crc_nxt   = crc8_byte(crc_cur, in_tdata);
          end
          BYTE_H_CRC: begin
            push = 1'b1;
            if (!tok_cur) begin
              push_job.status = ST_TEMP_CRC;
            end else if (!hum_ok) begin
              push_job.status = ST_HUM_CRC;
            end else begin
              push_job.status = ST_OK;
            end
            idx_nxt = BYTE_T_MSB;
            crc_nxt = CRC_INIT;
            tok_nxt = 1'b0;
          end
          default: begin
            idx_nxt = BYTE_T_MSB;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= BYTE_T_MSB;
      crc_r <= CRC_INIT;
      tok_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_t_r <= raw_t_nxt;
    raw_h_r <= raw_h_nxt;
  end

endmodule

@@ design/hsfd_queue.sv @@
// Short job queue between front and back end of the frame decoder.
// Depends on hsfd_pkg.
module hsfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hsfd_pkg::job_t push_job,
  output logic           full,
  output logic           q_valid,
  input  logic           pop,
  output hsfd_pkg::job_t pop_job
);
  import hsfd_pkg::*;

  job_t           fifo_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign pop_job = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ design/hsfd_back.sv @@
// Back end: scales raw words to centi-units, keeps the held reading and drives
// the result register. Depends on hsfd_pkg.
module hsfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           pop,
  input  hsfd_pkg::job_t pop_job,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [31:0]    out_tdata,
  output logic [2:0]     out_tuser
);
  import hsfd_pkg::*;

  // multiply stage
  logic        a_valid_r, a_valid_nxt;
  status_t     a_status_r;
  logic [30:0] a_tprod_r;
  logic [29:0] a_hprod_r;
  logic        a_load;
  // divide-by-65535 and output stage
  logic        adv;
  logic [31:0] tsum;
  logic [30:0] hsum;
  logic [14:0] tq;
  logic [13:0] hq;
  logic signed [15:0] temp_full;
  logic signed [14:0] held_t_r, held_t_nxt;
  logic [13:0] held_h_r, held_h_nxt;
  logic        held_v_r, held_v_nxt;
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r;
  logic signed [14:0] out_t_r;
  logic [13:0] out_h_r;
  logic        out_v_r;

  assign adv         = !out_valid_r || out_tready;
  assign a_load      = !a_valid_r || adv;
  assign pop         = q_valid && a_load;
  assign a_valid_nxt = a_load ? q_valid : a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_status_r <= pop_job.status;
      a_tprod_r  <= 31'(pop_job.raw_t) * 31'(TEMP_SCALE);
      a_hprod_r  <= 30'(pop_job.raw_h) * 30'(HUM_SCALE);
    end
  end

  // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for the product ranges here
  always_comb begin
    tsum      = {1'b0, a_tprod_r} + 32'(a_tprod_r >> 16) + 32'd1;
    hsum      = {1'b0, a_hprod_r} + 31'(a_hprod_r >> 16) + 31'd1;
    tq        = tsum[30:16];
    hq        = hsum[29:16];
    temp_full = $signed({1'b0, tq}) - TEMP_OFFSET;
  end

  always_comb begin
    held_t_nxt    = held_t_r;
    held_h_nxt    = held_h_r;
    held_v_nxt    = held_v_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = a_valid_r;
      if (a_valid_r && (a_status_r == ST_OK)) begin
        held_t_nxt = temp_full[14:0];
        held_h_nxt = hq;
        held_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_t_r    <= '0;
      held_h_r    <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      held_t_r    <= held_t_nxt;
      held_h_r    <= held_h_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      out_status_r <= a_status_r;
      out_t_r      <= held_t_nxt;
      out_h_r      <= held_h_nxt;
      out_v_r      <= held_v_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_h_r, out_t_r};
  assign out_tuser  = {out_v_r, out_status_r};

`ifndef SYNTHESIS
  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |=> held_v_r)
    else $error("held reading lost its valid flag");

  a_zero_before_good: assert property (@(posedge clk) disable iff (!rst_n)
    !held_v_r |-> (held_t_r == '0) && (held_h_r == '0))
    else $error("held reading changed without a good frame");

  a_ok_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_OK) |-> out_v_r)
    else $error("ok result without a valid reading");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_v_r |-> (out_t_r >= -15'sd4500) && (out_t_r <= 15'sd13000)
                              && (out_h_r <= 14'd10000))
    else $error("scaled reading out of range");
`endif

endmodule

@@ design/humidity_sensor_frame_decoder.sv @@
// Top level of the temperature/humidity sensor frame decoder.
// Depends on hsfd_pkg, hsfd_front, hsfd_queue and hsfd_back.
//
// Usage:
//   Input channel (in_*): one readout byte per beat, in sensor order
//   temperature MSB, LSB, CRC, humidity MSB, LSB, CRC. in_tuser[0] marks the
//   first byte of a frame (a partial frame is dropped silently); in_tuser[1]
//   flags a failed bus read, which drops any partial frame and reports status 3.
//   Result channel (out_*): one beat per finished frame or abort, carrying
//   status in out_tuser[1:0] (0 ok, 1 temp CRC, 2 humidity CRC, 3 bus error)
//   and the held reading. A frame with any bad CRC keeps the previous reading.
//   Path: after the last byte (or the abort beat) is taken, its job goes
//   through the queue, one multiply stage and one divide/output stage.
//   Throughput: one byte per cycle while the job queue is not full; the CRC
//   step is done per byte as it is taken, and the two multipliers are separate units.
//   Stall: a 4-entry job queue sits between front and back end; in_tready
//   drops only while that queue is full, so bytes inside a frame keep flowing
//   during short out_tready stalls.
//   Reset (rst_n low, synchronous): frame position cleared, CRC to 0xFF,
//   queue and pipeline empty, held reading zero with reading_valid low.
module humidity_sensor_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] frame_start, [1] abort
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi
  output logic [2:0]  out_tuser   // [1:0] status, [2] reading_valid
);
  import hsfd_pkg::*;

  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  job_t push_job;
  job_t pop_job;

  // byte tracking, CRC check, job posting
  hsfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // decouples byte intake from result delivery
  hsfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_job  (pop_job)
  );

  // scaling, held reading, result register
  hsfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .pop        (pop),
    .pop_job    (pop_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking bench for humidity_sensor_frame_decoder: byte stream in, readings out.
// Carries its own frame decoder (CRC-8, scaling, held reading) to predict each beat.
// Depends on hsfd_pkg (status codes, byte positions, CRC constants) and the RTL.
`timescale 1ns / 100ps

module tb;
  import hsfd_pkg::*;

  localparam int PHASE_ITEMS = 140;     // random beats per phase
  localparam int HOLD_CYCLES = 300;     // long out_tready hold-off, fills the job queue
  localparam int SETTLE      = 20;      // quiet cycles at the end, after the last owed reading
  localparam int CYCLE_LIMIT = 200000;

  // One expected result beat
  typedef struct {
    status_t     status;
    logic [14:0] temp;
    logic [13:0] hum;
    logic        valid;
  } reading_t;

  // How a directed row fills its data byte
  typedef enum {FILL_LIT, FILL_GOOD_CRC, FILL_BAD_CRC} fill_t;

  typedef struct {
    logic [7:0] data;
    bit         start;
    bit         abort;
    fill_t      fill;
    bit         pinned;   // expected result typed into the table
    reading_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic [1:0]  in_tuser;   // [0] frame_start, [1] abort
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [14:0] temperature_centi, [28:15] humidity_centi
  logic [2:0]  out_tuser;  // [1:0] status, [2] reading_valid

  humidity_sensor_frame_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Decoder shadow state
  logic [2:0]         frame_pos;
  logic [7:0]         crc_acc;
  logic [15:0]        raw_temp;
  bit                 temp_crc_good;
  logic [15:0]        raw_hum;
  logic signed [14:0] held_temp;
  logic [13:0]        held_hum;
  bit                 held_ok;

  reading_t reading_q[$];     // readings still owed by the block
  reading_t none_pinned = '{ST_OK, '0, '0, 1'b0};
  dir_row_t dir_tab[$];

  int errors      = 0;
  int items_sent  = 0;
  int results_got = 0;
  int status_seen[4];
  int cycles      = 0;
  int in_gap_pct;             // sender idles this often, in percent
  int out_stall_pct;          // receiver stalls this often
  int hold_reqs   = 0;        // bumped by the stimulus to ask for a long hold-off
  int hold_seen   = 0;
  int hold_left   = 0;

  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int i = 0; i < 8; i++) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic logic [7:0] crc_word(input logic [15:0] w);
    return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  function automatic void restart_frame();
    frame_pos     = BYTE_T_MSB;
    crc_acc       = CRC_INIT;
    temp_crc_good = 1'b0;
  endfunction

  // Advance the shadow decoder by one accepted beat; has is set when a result is owed
  function automatic void decode_byte(input logic [7:0] d, input bit st, input bit ab,
                                      output bit has, output reading_t r);
    int unsigned scaled;
    bit          hum_good;
    has = 1'b0;
    r   = none_pinned;
    if (ab) begin
      restart_frame();
      has = 1'b1;
      r   = '{ST_BUS, held_temp, held_hum, held_ok};
      return;
    end
    if (st || frame_pos >= FRAME_LEN) restart_frame();
    case (frame_pos)
      BYTE_T_MSB: begin
        raw_temp = {d, 8'h00};
        crc_acc  = crc_step(crc_acc, d);
      end
      BYTE_T_LSB: begin
        raw_temp[7:0] = d;
        crc_acc       = crc_step(crc_acc, d);
      end
      BYTE_T_CRC: begin
        temp_crc_good = (crc_acc == d);
        crc_acc       = CRC_INIT;
      end
      BYTE_H_MSB: begin
        raw_hum = {d, 8'h00};
        crc_acc = crc_step(crc_acc, d);
      end
      BYTE_H_LSB: begin
        raw_hum[7:0] = d;
        crc_acc      = crc_step(crc_acc, d);
      end
      default: begin
        hum_good = (crc_acc == d);
        has = 1'b1;
        if (!temp_crc_good) begin
          r.status = ST_TEMP_CRC;    // temperature wins when both words are bad
        end else if (!hum_good) begin
          r.status = ST_HUM_CRC;
        end else begin
          r.status  = ST_OK;
          scaled    = (32'd17500 * raw_temp) / 32'd65535;
          held_temp = 15'(int'(scaled) - 4500);
          held_hum  = 14'((32'd10000 * raw_hum) / 32'd65535);
          held_ok   = 1'b1;
        end
        r.temp  = held_temp;
        r.hum   = held_hum;
        r.valid = held_ok;
        restart_frame();
        return;
      end
    endcase
    frame_pos = frame_pos + 3'd1;
  endfunction

  function automatic dir_row_t row(input logic [7:0] d, input bit st, input bit ab,
                                   input fill_t f, input bit pin = 1'b0,
                                   input status_t s = ST_OK, input int t = 0,
                                   input int h = 0, input bit v = 1'b0);
    dir_row_t x;
    x.data   = d;
    x.start  = st;
    x.abort  = ab;
    x.fill   = f;
    x.pinned = pin;
    x.want   = '{s, 15'(t), 14'(h), v};
    return x;
  endfunction

  // Offer one beat, with a random idle gap in front; returns at the edge that takes it.
  // in_tready is sampled on the falling edge, where it is stable for the next rising edge.
  task automatic send_byte(input logic [7:0] d, input bit st, input bit ab,
                           input bit pinned, input reading_t pin_val);
    reading_t got;
    bit       has;
    bit       took;
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= {ab, st};
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    items_sent++;
    decode_byte(d, st, ab, has, got);
    if (has) reading_q.push_back(pinned ? pin_val : got);
  endtask

  // Sender stops and waits for every owed reading
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Mostly well-formed frames with random words; the rest aborts, cut frames and noise
  task automatic run_random(input int n_items);
    int          stop;
    int          pick;
    int          n_part;
    logic [15:0] rt, rh;
    logic [7:0]  ct, ch;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        rt = 16'($urandom);
        rh = 16'($urandom);
        if ($urandom_range(9) == 0) rt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(9) == 0) rh = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        ct = crc_word(rt);
        ch = crc_word(rh);
        if ($urandom_range(99) < 12) ct = ct ^ (8'h01 << $urandom_range(7));
        if ($urandom_range(99) < 12) ch = ch ^ (8'h01 << $urandom_range(7));
        send_byte(rt[15:8], $urandom_range(99) < 85, 1'b0, 1'b0, none_pinned);
        send_byte(rt[7:0], 1'b0, 1'b0, 1'b0, none_pinned);
        send_byte(ct, 1'b0, 1'b0, 1'b0, none_pinned);
        send_byte(rh[15:8], 1'b0, 1'b0, 1'b0, none_pinned);
        send_byte(rh[7:0], 1'b0, 1'b0, 1'b0, none_pinned);
        send_byte(ch, 1'b0, 1'b0, 1'b0, none_pinned);
      end else if (pick < 85) begin
        send_byte(8'($urandom), 1'($urandom_range(1)), 1'b1, 1'b0, none_pinned);
      end else if (pick < 93) begin
        n_part = $urandom_range(1, 5);
        for (int k = 0; k < n_part; k++)
          send_byte(8'($urandom), k == 0, 1'b0, 1'b0, none_pinned);
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(1)), 1'b0, 1'b0, none_pinned);
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off counted here when asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen  <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Result checker: a beat seen on the falling edge is taken at the next rising edge
  always @(negedge clk) begin : result_mon
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_got++;
      status_seen[out_tuser[1:0]]++;
      if (reading_q.size() == 0) begin
        $error("unexpected result beat: status %0d temp %0d hum %0d valid %0b",
               out_tuser[1:0], $signed(out_tdata[14:0]), out_tdata[28:15], out_tuser[2]);
        errors++;
      end else begin
        want = reading_q.pop_front();
        if (out_tuser[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser[1:0]);
          errors++;
        end
        if (out_tdata[14:0] !== want.temp) begin
          $error("temperature_centi: expected %0d, got %0d",
                 $signed(want.temp), $signed(out_tdata[14:0]));
          errors++;
        end
        if (out_tdata[28:15] !== want.hum) begin
          $error("humidity_centi: expected %0d, got %0d", want.hum, out_tdata[28:15]);
          errors++;
        end
        if (out_tuser[2] !== want.valid) begin
          $error("reading_valid: expected %0b, got %0b", want.valid, out_tuser[2]);
          errors++;
        end
        if (out_tdata[31:29] !== 3'b000) begin
          $error("tdata pad: expected 0, got %0d", out_tdata[31:29]);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] prev1, prev2, d;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    in_tuser      = 2'b00;
    out_tready    = 1'b0;
    in_gap_pct    = 25;
    out_stall_pct = 51;
    restart_frame();
    raw_temp  = '0;
    raw_hum   = '0;
    held_temp = '0;
    held_hum  = '0;
    held_ok   = 1'b0;
    prev1     = 8'h00;
    prev2     = 8'h00;

    // Directed frames; good CRC rows get the checksum of the two bytes in front of them, bad ones flip its bit 0
    // bus error straight out of reset: nothing held yet
    dir_tab.push_back(row(8'h00, 1'b0, 1'b1, FILL_LIT, 1'b1, ST_BUS, 0, 0, 1'b0));
    // all-zero words, first byte without the start flag while idle
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_GOOD_CRC));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_GOOD_CRC, 1'b1, ST_OK, -4500, 0, 1'b1));
    // partial frame, silently dropped by the next start
    dir_tab.push_back(row(8'h55, 1'b1, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h66, 1'b0, 1'b0, FILL_LIT));
    // full-scale words
    dir_tab.push_back(row(8'hFF, 1'b1, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'hFF, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_GOOD_CRC));
    dir_tab.push_back(row(8'hFF, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'hFF, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_GOOD_CRC, 1'b1, ST_OK, 13000, 10000, 1'b1));
    // both checksums bad: temperature reported, reading kept
    dir_tab.push_back(row(8'h12, 1'b1, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h34, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_BAD_CRC));
    dir_tab.push_back(row(8'h56, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h78, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_BAD_CRC, 1'b1, ST_TEMP_CRC, 13000, 10000, 1'b1));
    // humidity checksum bad only, no start flag after a finished frame
    dir_tab.push_back(row(8'h9A, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'hBC, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_GOOD_CRC));
    dir_tab.push_back(row(8'hDE, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'hF0, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, FILL_BAD_CRC, 1'b1, ST_HUM_CRC, 13000, 10000, 1'b1));
    // abort in mid-frame, start flag also up on the abort beat
    dir_tab.push_back(row(8'hBE, 1'b1, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'hEF, 1'b0, 1'b0, FILL_LIT));
    dir_tab.push_back(row(8'hA5, 1'b1, 1'b1, FILL_LIT, 1'b1, ST_BUS, 13000, 10000, 1'b1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].fill)
        FILL_GOOD_CRC: d = crc_step(crc_step(CRC_INIT, prev2), prev1);
        FILL_BAD_CRC:  d = crc_step(crc_step(CRC_INIT, prev2), prev1) ^ 8'h01;
        default:       d = dir_tab[i].data;
      endcase
      send_byte(d, dir_tab[i].start, dir_tab[i].abort, dir_tab[i].pinned, dir_tab[i].want);
      prev2 = prev1;
      prev1 = d;
    end
    wait_drained();

    // Phase 1: sender idles 25 %, receiver 51 %
    run_random(PHASE_ITEMS);
    wait_drained();

    // Phase 2: roles swapped, with a full drain halfway through
    in_gap_pct    = 51;
    out_stall_pct = 25;
    run_random(PHASE_ITEMS / 2);
    wait_drained();
    run_random(PHASE_ITEMS / 2);
    wait_drained();

    // Phase 3: back to back, opened by a long receiver hold-off that backs up the queue
    in_gap_pct    = 0;
    out_stall_pct = 0;
    hold_reqs++;
    run_random(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (reading_q.size() != 0) begin
      $error("%0d expected readings never arrived", reading_q.size());
      errors++;
    end
    $display("Sent %0d beats, checked %0d readings in %0d cycles (errors %0d).",
             items_sent, results_got, cycles, errors);
    $display("Readings by status: ok %0d, temp crc %0d, humidity crc %0d, bus %0d.",
             status_seen[ST_OK], status_seen[ST_TEMP_CRC], status_seen[ST_HUM_CRC],
             status_seen[ST_BUS]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/hsfd_pkg.sv
design/hsfd_front.sv
design/hsfd_queue.sv
design/hsfd_back.sv
design/humidity_sensor_frame_decoder.sv
tb/tb.sv
